// ===== src/cbba_pkg.sv =====
// Shared constants, types and helpers for the chunked arena bump allocator.
// Used by cbba_cell and by chunked_arena_bump_allocator; depends on nothing.
`timescale 1ns / 1ps
package cbba_pkg;

   localparam int MAX_CHUNKS = 16;
   localparam int IDX_W      = $clog2(MAX_CHUNKS);
   localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 24;
   localparam int ALOG_W     = 4;
   localparam int PAD_W      = (1 << ALOG_W) - 1;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MINIMUM     = 2'd2;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_RESET = 1'b1;

   // Values broadcast to every cell during a scan.
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [PAD_W-1:0]  amask;
      logic [IDX_W-1:0]  target;
      logic [CNT_W-1:0]  count;
   } scan_type;

   // Link handed from one cell to the next.
   typedef struct packed {
      logic             live;
      logic             hit;
      logic [IDX_W-1:0] idx;
      logic [PAD_W-1:0] off;
   } link_type;

   // Padding that brings addr up to the alignment given by amask.
   function automatic logic [PAD_W-1:0] pad_of(input logic [ADDR_W-1:0] addr,
                                               input logic [PAD_W-1:0] amask);
      logic [PAD_W-1:0] neg;
      neg = ~addr[PAD_W-1:0] + {{(PAD_W-1){1'b0}}, 1'b1};
      return neg & amask;
   endfunction

endpackage

// ===== src/chunked_arena_bump_allocator.sv =====
// Top level of the chunked arena bump allocator: request sequencer, totals
// and the row of chunk cells. Depends on cbba_pkg and cbba_cell.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; its one result
// appears on the rsp_ ports for a single cycle, flagged by rsp_strobe, and
// the receiver cannot stall it. A reset transaction goes straight to the
// result. An allocation first creates the first chunk if none exists, then
// tests the current chunk. When it does not fit, a token runs once along
// the row of MAX_CHUNKS chunk cells, one cell per cycle, looking for the
// first later chunk that fits; a new chunk is appended when none does. A
// request that fails because the chunk table is full skips placement and
// the high-water update. busy stays high through the result strobe.
// Configuration writes are always accepted and are meant to be made while
// busy is low; they only affect chunks appended afterwards.
module chunked_arena_bump_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_type,
   input  logic [cbba_pkg::SIZE_W-1:0]     req_size_bytes,
   input  logic [cbba_pkg::ALOG_W-1:0]     req_align_log2,
   output logic                            rsp_strobe,
   output logic [31:0]                     rsp_address,
   output logic                            rsp_added_chunk,
   output logic                            rsp_failed,
   output logic [31:0]                     rsp_used_bytes,
   output logic [31:0]                     rsp_high_water,
   output logic [31:0]                     rsp_reserved_bytes,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cbba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_data
);

   localparam int N = cbba_pkg::MAX_CHUNKS;
   localparam int IW = cbba_pkg::IDX_W;
   localparam int CW = cbba_pkg::CNT_W;
   localparam int AW = cbba_pkg::ADDR_W;
   localparam int PW = cbba_pkg::PAD_W;
   localparam int SW = cbba_pkg::SIZE_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_FIRST, ST_CALC, ST_TEST, ST_SCAN,
      ST_APPEND, ST_PLACE, ST_PEAK, ST_RESP
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [AW-1:0] region_base_ff;
   logic [31:0]   initial_ff, minimum_ff;

   // Arena state.
   logic [CW-1:0] count_ff;
   logic [IW-1:0] cur_ff, target_ff;
   logic [31:0]   fill_ff, used_ff, peak_ff, resv_ff, last_cap_ff;
   logic [AW-1:0] last_end_ff;

   // Request in flight.
   logic [SW-1:0] size_ff;
   logic [PW-1:0] amask_ff;
   logic [32:0]   off_ff;
   logic          tok_ff;
   logic [31:0]   addr_ff;
   logic          added_ff, failed_ff;

   // Cell row.
   cbba_pkg::scan_type  scan;
   cbba_pkg::link_type  links [N+1];
   logic [AW-1:0]       cell_start [N];
   logic [31:0]         cell_cap   [N];
   logic                wr_en;
   logic [IW-1:0]       wr_idx;
   logic [AW-1:0]       wr_start;
   logic [31:0]         wr_cap;

   // Combinational helpers.
   logic [AW-1:0] sel_start;
   logic [31:0]   sel_cap;
   logic [PW-1:0] pad_cur, pad_new;
   logic [32:0]   off_cur;
   logic          fit_cur;
   logic [31:0]   first_cap, new_cap;
   logic [32:0]   cap_need, cap_dbl, cap_max;
   logic [32:0]   resv_sum, used_sum;
   logic [31:0]   resv_sat, used_sat;
   logic [PW:0]   align_val;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);

   // The scan token enters the row with no hit recorded.
   assign links[0] = {tok_ff, 1'b0, {IW{1'b0}}, {PW{1'b0}}};

   always_comb begin
      sel_start = cell_start[target_ff];
      sel_cap   = cell_cap[target_ff];
      pad_cur   = cbba_pkg::pad_of(sel_start + fill_ff, amask_ff);
      off_cur   = {1'b0, fill_ff} + {{(33-PW){1'b0}}, pad_cur};
      fit_cur   = ({1'b0, off_ff} + {{(34-SW){1'b0}}, size_ff}) <= {2'b00, sel_cap};

      first_cap = (minimum_ff > initial_ff) ? minimum_ff : initial_ff;

      // A new chunk holds at least the request plus its alignment, twice the
      // last chunk and the minimum, saturated to 32 bits.
      align_val = {1'b0, amask_ff} + {{PW{1'b0}}, 1'b1};
      cap_need  = {{(33-SW){1'b0}}, size_ff} + {{(32-PW){1'b0}}, align_val};
      cap_dbl   = {last_cap_ff, 1'b0};
      cap_max   = (cap_dbl > cap_need) ? cap_dbl : cap_need;
      if ({1'b0, minimum_ff} > cap_max) begin
         cap_max = {1'b0, minimum_ff};
      end
      new_cap   = cap_max[32] ? 32'hFFFF_FFFF : cap_max[31:0];
      pad_new   = cbba_pkg::pad_of(last_end_ff, amask_ff);

      wr_en    = (state_ff == ST_FIRST) || (state_ff == ST_APPEND);
      wr_idx   = (state_ff == ST_FIRST) ? '0 : count_ff[IW-1:0];
      wr_start = (state_ff == ST_FIRST) ? region_base_ff : last_end_ff;
      wr_cap   = (state_ff == ST_FIRST) ? first_cap : new_cap;
      resv_sum = {1'b0, resv_ff} + {1'b0, wr_cap};
      resv_sat = resv_sum[32] ? 32'hFFFF_FFFF : resv_sum[31:0];

      used_sum = {1'b0, used_ff} + {9'd0, size_ff};
      used_sat = used_sum[32] ? 32'hFFFF_FFFF : used_sum[31:0];

      scan.size   = size_ff;
      scan.amask  = amask_ff;
      scan.target = target_ff;
      scan.count  = count_ff;
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      cbba_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .my_idx   (IW'(g)),
         .wr_en    (wr_en),
         .wr_idx   (wr_idx),
         .wr_start (wr_start),
         .wr_cap   (wr_cap),
         .scan     (scan),
         .link_in  (links[g]),
         .link_out (links[g+1]),
         .start_o  (cell_start[g]),
         .cap_o    (cell_cap[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         region_base_ff <= '0;
         initial_ff     <= 32'd4096;
         minimum_ff     <= 32'd4096;
         count_ff       <= '0;
         cur_ff         <= '0;
         target_ff      <= '0;
         fill_ff        <= '0;
         used_ff        <= '0;
         peak_ff        <= '0;
         resv_ff        <= '0;
         tok_ff         <= 1'b0;
         added_ff       <= 1'b0;
         failed_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cbba_pkg::CSR_REGION_BASE: region_base_ff <= csr_data;
               cbba_pkg::CSR_INITIAL:     initial_ff     <= csr_data;
               cbba_pkg::CSR_MINIMUM:     minimum_ff     <= csr_data;
               default: ;
            endcase
         end
         tok_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  size_ff   <= req_size_bytes;
                  amask_ff  <= PW'((32'd1 << req_align_log2) - 32'd1);
                  target_ff <= cur_ff;
                  addr_ff   <= '0;
                  added_ff  <= 1'b0;
                  failed_ff <= 1'b0;
                  if (req_type == cbba_pkg::REQ_RESET) begin
                     cur_ff   <= '0;
                     fill_ff  <= '0;
                     used_ff  <= '0;
                     state_ff <= ST_RESP;
                  end else if (count_ff == '0) begin
                     state_ff <= ST_FIRST;
                  end else begin
                     state_ff <= ST_CALC;
                  end
               end
            end
            ST_FIRST: begin
               last_end_ff <= region_base_ff + first_cap;
               last_cap_ff <= first_cap;
               count_ff    <= CW'(1);
               resv_ff     <= resv_sat;
               cur_ff      <= '0;
               target_ff   <= '0;
               fill_ff     <= '0;
               added_ff    <= 1'b1;
               state_ff    <= ST_CALC;
            end
            ST_CALC: begin
               off_ff   <= off_cur;
               state_ff <= ST_TEST;
            end
            ST_TEST: begin
               if (fit_cur) begin
                  state_ff <= ST_PLACE;
               end else begin
                  tok_ff   <= 1'b1;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (links[N].live) begin
                  if (links[N].hit) begin
                     target_ff <= links[N].idx;
                     off_ff    <= {{(33-PW){1'b0}}, links[N].off};
                     state_ff  <= ST_PLACE;
                  end else if (count_ff == CW'(N)) begin
                     failed_ff <= 1'b1;
                     added_ff  <= 1'b0;
                     state_ff  <= ST_RESP;
                  end else begin
                     state_ff <= ST_APPEND;
                  end
               end
            end
            ST_APPEND: begin
               last_end_ff <= last_end_ff + new_cap;
               last_cap_ff <= new_cap;
               count_ff    <= count_ff + CW'(1);
               resv_ff     <= resv_sat;
               target_ff   <= count_ff[IW-1:0];
               off_ff      <= {{(33-PW){1'b0}}, pad_new};
               added_ff    <= 1'b1;
               state_ff    <= ST_PLACE;
            end
            ST_PLACE: begin
               // The placement always lies inside the chunk, so the new fill
               // fits in 32 bits.
               cur_ff   <= target_ff;
               addr_ff  <= sel_start + off_ff[31:0];
               fill_ff  <= off_ff[31:0] + {8'd0, size_ff};
               used_ff  <= used_sat;
               state_ff <= ST_PEAK;
            end
            ST_PEAK: begin
               if (used_ff > peak_ff) begin
                  peak_ff <= used_ff;
               end
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe         = (state_ff == ST_RESP);
   assign rsp_address        = addr_ff;
   assign rsp_added_chunk    = added_ff;
   assign rsp_failed         = failed_ff;
   assign rsp_used_bytes     = used_ff;
   assign rsp_high_water     = peak_ff;
   assign rsp_reserved_bytes = resv_ff;

endmodule

// ===== src/cbba_cell.sv =====
// One chunk cell: holds a chunk's start and capacity and forms one stage of
// the first-fit scan chain. Depends on cbba_pkg.
`timescale 1ns / 1ps
module cbba_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [cbba_pkg::IDX_W-1:0]   my_idx,
   input  logic                         wr_en,
   input  logic [cbba_pkg::IDX_W-1:0]   wr_idx,
   input  logic [cbba_pkg::ADDR_W-1:0]  wr_start,
   input  logic [31:0]                  wr_cap,
   input  cbba_pkg::scan_type           scan,
   input  cbba_pkg::link_type           link_in,
   output cbba_pkg::link_type           link_out,
   output logic [cbba_pkg::ADDR_W-1:0]  start_o,
   output logic [31:0]                  cap_o
);

   logic [cbba_pkg::ADDR_W-1:0] start_ff;
   logic [31:0]                 cap_ff;
   cbba_pkg::link_type          link_ff, link_in_c;
   logic [cbba_pkg::PAD_W-1:0]  pad;
   logic                        eligible, fits;

   always_comb begin
      pad      = cbba_pkg::pad_of(start_ff, scan.amask);
      eligible = (my_idx > scan.target) && ({1'b0, my_idx} < scan.count);
      fits     = ({8'd0, {{(cbba_pkg::SIZE_W+1-cbba_pkg::PAD_W){1'b0}}, pad} +
                  {1'b0, scan.size}} <= {1'b0, cap_ff});
      link_in_c = link_in;
      if (link_in.live && !link_in.hit && eligible && fits) begin
         link_in_c.hit = 1'b1;
         link_in_c.idx = my_idx;
         link_in_c.off = pad;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_idx == my_idx)) begin
         start_ff <= wr_start;
         cap_ff   <= wr_cap;
      end
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_c;
      end
   end

   assign link_out = link_ff;
   assign start_o  = start_ff;
   assign cap_o    = cap_ff;

endmodule

// ===== sim/chunked_arena_bump_allocator_tb.sv =====
// Self-checking testbench for the chunked arena bump allocator: directed and random
// allocate and rewind transactions against a behavioural predictor of the chunk table.
// Depends on cbba_pkg and the chunked_arena_bump_allocator RTL.
`timescale 1ns / 1ps
module chunked_arena_bump_allocator_tb;

   typedef struct packed {
      logic                        kind;
      logic [cbba_pkg::SIZE_W-1:0] size;
      logic [cbba_pkg::ALOG_W-1:0] alog;
   } alloc_req_type;

   typedef struct packed {
      logic [31:0] address;
      logic        added;
      logic        failed;
      logic [31:0] used;
      logic [31:0] high;
      logic [31:0] reserved;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = cbba_pkg::REQ_ALLOC;
   logic [cbba_pkg::SIZE_W-1:0] req_size_bytes = '0;
   logic [cbba_pkg::ALOG_W-1:0] req_align_log2 = '0;
   logic rsp_strobe;
   logic [31:0] rsp_address, rsp_used_bytes, rsp_high_water, rsp_reserved_bytes;
   logic rsp_added_chunk, rsp_failed;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cbba_pkg::CSR_IDX_W-1:0] csr_index = cbba_pkg::CSR_REGION_BASE;
   logic [31:0] csr_data = '0;

   chunked_arena_bump_allocator DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state, kept 64 bits wide so that saturation and wrap are explicit.
   logic [63:0] p_base, p_initial, p_minimum;
   logic [63:0] p_start [cbba_pkg::MAX_CHUNKS];
   logic [63:0] p_cap   [cbba_pkg::MAX_CHUNKS];
   int unsigned p_count, p_current;
   logic [63:0] p_fill, p_used, p_peak, p_reserved;

   alloc_req_type pending_reqs[$];
   grant_type     expected_grants[$];
   int unsigned mismatches = 0;
   int unsigned grants_seen = 0;
   int unsigned chunks_added = 0, fails_seen = 0;
   bit idle_enable = 1'b1;
   bit hold_off = 1'b0;

   function automatic logic [63:0] sat32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   function automatic logic [63:0] pad_up(input logic [63:0] addr, input logic [63:0] align);
      return (align - (addr & (align - 64'd1))) & (align - 64'd1);
   endfunction

   function automatic void add_chunk(input logic [63:0] cap);
      logic [63:0] s;
      s = (p_count > 0) ? p_start[p_count-1] + p_cap[p_count-1] : p_base;
      p_start[p_count] = s & 64'hFFFF_FFFF;
      p_cap[p_count] = cap;
      p_count++;
      p_reserved = sat32(p_reserved + cap);
   endfunction

   // Works out the grant for one allocation or rewind and advances the predictor.
   function automatic grant_type predict_grant(input alloc_req_type r);
      grant_type g;
      logic [63:0] size, align, offset, off, cap, dbl;
      int unsigned tgt;
      bit placed;
      g = '0;
      if (r.kind == cbba_pkg::REQ_RESET) begin
         p_current = 0;
         p_fill = 64'd0;
         p_used = 64'd0;
      end else begin
         size = {40'd0, r.size};
         align = 64'd1 << r.alog;
         tgt = p_current;
         offset = 64'd0;
         placed = 1'b0;
         if (p_count == 0) begin
            add_chunk((p_minimum > p_initial) ? p_minimum : p_initial);
            p_current = 0;
            p_fill = 64'd0;
            tgt = 0;
            g.added = 1'b1;
         end
         if (tgt < p_count) begin
            offset = p_fill + pad_up(p_start[tgt] + p_fill, align);
            placed = (offset + size <= p_cap[tgt]);
         end
         if (!placed) begin
            for (int unsigned n = tgt + 1; n < p_count; n++) begin
               off = pad_up(p_start[n], align);
               if (!placed && off + size <= p_cap[n]) begin
                  tgt = n;
                  offset = off;
                  placed = 1'b1;
               end
            end
         end
         if (!placed) begin
            if (p_count >= cbba_pkg::MAX_CHUNKS) begin
               g.failed = 1'b1;
               g.added = 1'b0;
            end else begin
               cap = size + align;
               dbl = p_cap[p_count-1] * 64'd2;
               if (dbl > cap) cap = dbl;
               if (p_minimum > cap) cap = p_minimum;
               add_chunk(sat32(cap));
               tgt = p_count - 1;
               offset = pad_up(p_start[tgt], align);
               g.added = 1'b1;
               placed = 1'b1;
            end
         end
         if (placed) begin
            p_current = tgt;
            g.address = 32'((p_start[tgt] + offset) & 64'hFFFF_FFFF);
            p_fill = offset + size;
            p_used = sat32(p_used + size);
            if (p_used > p_peak) p_peak = p_used;
         end
      end
      g.used = p_used[31:0];
      g.high = p_peak[31:0];
      g.reserved = p_reserved[31:0];
      return g;
   endfunction

   // Driver: start is held until the block accepts, so one NBA per signal per edge.
   always @(posedge clock) begin
      alloc_req_type r;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         r = pending_reqs.pop_front();
         expected_grants = {expected_grants, predict_grant(r)};
         if (pending_reqs.size() > 0 && !hold_off &&
             !(idle_enable && $urandom_range(99) < 21)) begin
            req_type <= pending_reqs[0].kind;
            req_size_bytes <= pending_reqs[0].size;
            req_align_log2 <= pending_reqs[0].alog;
         end else begin
            start <= 1'b0;
         end
      end else if (!start && pending_reqs.size() > 0 && !hold_off &&
                   !(idle_enable && $urandom_range(99) < 21)) begin
         start <= 1'b1;
         req_type <= pending_reqs[0].kind;
         req_size_bytes <= pending_reqs[0].size;
         req_align_log2 <= pending_reqs[0].alog;
      end
   end

   // Monitor: every strobe is one result transaction, compared with the oldest prediction.
   always @(posedge clock) begin
      grant_type e, a;
      if (!reset && rsp_strobe) begin
         a = '{rsp_address, rsp_added_chunk, rsp_failed, rsp_used_bytes,
               rsp_high_water, rsp_reserved_bytes};
         grants_seen++;
         if (expected_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result transaction %p", a);
         end else begin
            e = expected_grants.pop_front();
            if (a.added) chunks_added++;
            if (a.failed) fails_seen++;
            if (a !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result %0d expected %p got %p", grants_seen, e, a);
            end
         end
      end
   end

   // Watchdog: any accepted transaction restarts the count.
   int unsigned quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [cbba_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         cbba_pkg::CSR_REGION_BASE: p_base = {32'd0, val};
         cbba_pkg::CSR_INITIAL:     p_initial = {32'd0, val};
         default:                   p_minimum = {32'd0, val};
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic queue_req(input logic kind, input int unsigned size, input int unsigned alog);
      alloc_req_type r;
      r.kind = kind;
      r.size = cbba_pkg::SIZE_W'(size);
      r.alog = cbba_pkg::ALOG_W'(alog);
      pending_reqs = {pending_reqs, r};
   endtask

   // Lets every queued transaction finish, then allows the longest scan to drain.
   task automatic drain();
      while (!(pending_reqs.size() == 0 && !start && expected_grants.size() == 0))
         @(posedge clock);
      repeat (cbba_pkg::MAX_CHUNKS + 12) @(posedge clock);
   endtask

   // Mostly small requests with the odd large one, rewinds sprinkled in.
   task automatic random_phase(input int unsigned n);
      int unsigned sz;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8) begin
            queue_req(cbba_pkg::REQ_RESET, $urandom, $urandom);
         end else begin
            case ($urandom_range(9))
               0:       sz = $urandom_range(24'hFFFFFF);
               1:       sz = $urandom_range(65535);
               2:       sz = 0;
               default: sz = $urandom_range(600);
            endcase
            queue_req(cbba_pkg::REQ_ALLOC, sz, $urandom_range(15));
         end
      end
   endtask

   initial begin
      p_base = 64'd0;
      p_initial = 64'd4096;
      p_minimum = 64'd4096;
      p_count = 0;
      p_current = 0;
      p_fill = 64'd0;
      p_used = 64'd0;
      p_peak = 64'd0;
      p_reserved = 64'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Defaults first: lazy first chunk, alignment extremes, rewind, huge requests.
      queue_req(cbba_pkg::REQ_RESET, 0, 0);
      queue_req(cbba_pkg::REQ_ALLOC, 0, 0);
      queue_req(cbba_pkg::REQ_ALLOC, 1, 15);
      queue_req(cbba_pkg::REQ_ALLOC, 100, 12);
      queue_req(cbba_pkg::REQ_ALLOC, 5000, 3);
      queue_req(cbba_pkg::REQ_ALLOC, 24'hFFFFFF, 4'hF);
      queue_req(cbba_pkg::REQ_ALLOC, 24'hAAAAAA, 4'h5);
      queue_req(cbba_pkg::REQ_ALLOC, 24'h555555, 4'hA);
      queue_req(cbba_pkg::REQ_RESET, 24'hFFFFFF, 4'hF);
      queue_req(cbba_pkg::REQ_ALLOC, 8000, 0);
      queue_req(cbba_pkg::REQ_ALLOC, 24'hFFFFFF, 13);
      queue_req(cbba_pkg::REQ_ALLOC, 24'hFFFFFF, 14);
      for (int i = 0; i < 8; i++) queue_req(cbba_pkg::REQ_ALLOC, 24'hFFFFFF, 0);
      drain();

      // Large base near the top of the address space so the chunks wrap round.
      write_reg(cbba_pkg::CSR_REGION_BASE, 32'hFFFF_F001);
      write_reg(cbba_pkg::CSR_INITIAL, 32'd0);
      write_reg(cbba_pkg::CSR_MINIMUM, 32'd1);
      random_phase(150);
      drain();

      write_reg(cbba_pkg::CSR_REGION_BASE, $urandom);
      write_reg(cbba_pkg::CSR_INITIAL, 32'hFFFF_FFFF);
      write_reg(cbba_pkg::CSR_MINIMUM, 32'hFFFF_FFFF);
      random_phase(100);
      // Part-way through, the sender holds off until every outstanding result
      // has arrived, then carries on.
      while (pending_reqs.size() > 50) @(posedge clock);
      hold_off = 1'b1;
      while (start || expected_grants.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      hold_off = 1'b0;
      drain();
      write_reg(cbba_pkg::CSR_INITIAL, $urandom_range(1 << 20));
      write_reg(cbba_pkg::CSR_MINIMUM, $urandom_range(1, 4096));
      idle_enable = 1'b0;
      random_phase(200);
      drain();
      idle_enable = 1'b1;
      write_reg(cbba_pkg::CSR_REGION_BASE, 32'h0);
      write_reg(cbba_pkg::CSR_MINIMUM, 32'd4096);
      random_phase(230);
      drain();

      $display("Covered %0d result transactions, %0d chunk appends, %0d table-full failures.",
               grants_seen, chunks_added, fails_seen);
      $display("Register settings included zero, one and all-ones sizes and a wrapping base.");
      if (mismatches == 0 && expected_grants.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== chunked_arena_bump_allocator.f =====
src/cbba_pkg.sv
src/cbba_cell.sv
src/chunked_arena_bump_allocator.sv
sim/chunked_arena_bump_allocator_tb.sv
